FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with async active-low reset; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

FILE: src/efs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// efs_pkg
// Shared constants, types and saturation helpers of the exchange stencil.
// ---------------------------------------------------------------------------
package efs_pkg;

	localparam int NODE_COUNT = 4096;
	localparam int NEIGHBOURS = 6;
	localparam int NODE_AW    = $clog2(NODE_COUNT);
	localparam int NGB_DEPTH  = NODE_COUNT * NEIGHBOURS;
	localparam int NGB_AW     = $clog2(NGB_DEPTH);
	localparam int CFG_REGS   = 4;

	// shared multiplier operand and accumulator widths
	localparam int MAC_AW = 36;
	localparam int MAC_BW = 18;
	localparam int PROD_W = MAC_AW + MAC_BW;
	localparam int ACC_W  = 104;
	localparam int SUM_W  = 54;

	localparam logic [1:0] REQ_WR_NODE = 2'd0;
	localparam logic [1:0] REQ_WR_NGB  = 2'd1;
	localparam logic [1:0] REQ_COMPUTE = 2'd2;
	localparam logic [1:0] REQ_TOTAL   = 2'd3;

	localparam logic [1:0] CFG_INV_DX  = 2'd0;
	localparam logic [1:0] CFG_INV_DY  = 2'd1;
	localparam logic [1:0] CFG_INV_DZ  = 2'd2;
	localparam logic [1:0] CFG_VOLUME  = 2'd3;
	localparam logic [31:0] CFG_RESET  = 32'd65536;

	localparam logic signed [ACC_W-1:0] MAX48_A = ACC_W'(64'sh0000_7FFF_FFFF_FFFF);
	localparam logic signed [ACC_W-1:0] MIN48_A = -MAX48_A - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] MAX64_A = ACC_W'(65'sh0_7FFF_FFFF_FFFF_FFFF);
	localparam logic signed [ACC_W-1:0] MIN64_A = -MAX64_A - ACC_W'(1);

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_RD_OWN, ST_LD_OWN, ST_RD_NGB, ST_CHK_NGB, ST_LD_NB,
		ST_DIFF, ST_DIFF_W, ST_KL, ST_KH, ST_K_W, ST_ACC, ST_NEXT,
		ST_FLD, ST_FLD_W, ST_FLD_SAV, ST_EN, ST_EN_W, ST_EN_SAV,
		ST_TOT, ST_TOT_W, ST_TOT_SAV, ST_OUT
	} state_t;

	typedef struct packed {
		logic                      vld;
		logic                      clr;
		logic [5:0]                shift;
		logic signed [MAC_AW-1:0]  a;
		logic signed [MAC_BW-1:0]  b;
	} mac_op_t;

	// floor(x / 2^16) clamped to 48 bits
	function automatic logic signed [47:0] sat48(input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] t;
		t = x >>> 16;
		if (t > MAX48_A)
			return MAX48_A[47:0];
		else if (t < MIN48_A)
			return MIN48_A[47:0];
		return t[47:0];
	endfunction

	// floor(x / 2^16) clamped to 64 bits
	function automatic logic signed [63:0] sat64(input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] t;
		t = x >>> 16;
		if (t > MAX64_A)
			return MAX64_A[63:0];
		else if (t < MIN64_A)
			return MIN64_A[63:0];
		return t[63:0];
	endfunction

endpackage

FILE: src/efs_mac.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// efs_mac
// Shared 36x18 signed multiplier with registered product and shifted accumulate.
// ---------------------------------------------------------------------------
module efs_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  efs_pkg::mac_op_t                      op,
	output logic signed [efs_pkg::ACC_W-1:0]      acc
);

	logic signed [efs_pkg::PROD_W-1:0] prod_s1;
	logic [5:0]                        shift_s1;
	logic                              vld_s1;
	logic                              clr_s1;
	logic signed [efs_pkg::ACC_W-1:0]  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			clr_s1 <= 1'b0;
		end else begin
			vld_s1 <= op.vld;
			clr_s1 <= op.clr;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= op.a * op.b;
		shift_s1 <= op.shift;
		if (vld_s1) begin
			if (clr_s1)
				acc_q <= efs_pkg::ACC_W'(prod_s1) <<< shift_s1;
			else
				acc_q <= acc_q + (efs_pkg::ACC_W'(prod_s1) <<< shift_s1);
		end
	end

	assign acc = acc_q;

endmodule

FILE: src/exchange_field_stencil.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// exchange_field_stencil
// Six-neighbour exchange field and energy engine on one shared multiplier.
// ---------------------------------------------------------------------------
// Input stream s_*: one request per transfer, kind in s_tuser. Node and
// neighbour writes complete in the accept cycle and give no result.
// A compute transfer returns one node result, a total transfer one total
// result, on the m_* stream (m_tuser = result kind).
// Config channel cfg_*: always ready; write only while the block is idle.
// A compute on a magnetic node walks all six neighbour slots and skips the
// multiplies for an absent neighbour or for one with no material; a compute
// on a non-magnetic node skips the walk.
// Each neighbour component costs one difference multiply and two
// coefficient multiplies on the single 36x18 MAC; field and energy take
// four and two partial products per component. The node stores are single
// read port memories read one address per cycle.
// After reset the energy store is swept to zero, one entry a cycle, through
// all NODE_COUNT (4096) entries; s_tready stays low meanwhile.
// A stalled result waits in the output register; a new request is taken,
// but its result is held back until that register frees.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module exchange_field_stencil (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// node_index, spin_x, spin_y, spin_z, inv_sat, exch_coeff, ngb_slot,
	// ngb_index, zero pad
	input  logic [127:0] s_tdata,
	// req_type
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// field_x, field_y, field_z, node_energy, total_energy
	output logic [255:0] m_tdata,
	// result_kind
	output logic [0:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int NAW = efs_pkg::NODE_AW;
	localparam int GAW = efs_pkg::NGB_AW;

	// input field unpack
	logic [11:0] in_node;
	logic [47:0] in_spin;
	logic [31:0] in_isat;
	logic [15:0] in_exch;
	logic [2:0]  in_slot;
	logic [12:0] in_ngb;
	logic        s_xfer;
	logic        in_node_ok;

	assign in_node    = s_tdata[11:0];
	assign in_spin    = s_tdata[59:12];
	assign in_isat    = s_tdata[91:60];
	assign in_exch    = s_tdata[107:92];
	assign in_slot    = s_tdata[110:108];
	assign in_ngb     = s_tdata[123:111];
	assign s_xfer     = s_tvalid && s_tready;
	assign in_node_ok = 32'(in_node) < efs_pkg::NODE_COUNT;

	// control
	efs_pkg::state_t state_q, state_d;
	logic [NAW-1:0]  clr_q;
	logic [1:0]      c_q;
	logic [2:0]      j_q;
	logic [2:0]      p_q;
	logic [NAW-1:0]  node_q;
	logic            node_ok_q;
	logic            out_go;

	// datapath
	logic [31:0]               cfg_q [efs_pkg::CFG_REGS];
	logic signed [15:0]        own_spin_q [3];
	logic signed [15:0]        nb_spin_q [3];
	logic [31:0]               own_isat_q;
	logic [15:0]               own_exch_q;
	logic signed [47:0]        own_en_q;
	logic signed [efs_pkg::SUM_W-1:0] s_q [3];
	logic signed [47:0]        fld_q [3];
	logic signed [47:0]        en_q;
	logic signed [63:0]        tot_q;
	logic                      kind_q;
	logic signed [63:0]        sum_q;
	logic [255:0]              m_tdata_q;
	logic                      m_tuser_q;
	logic                      m_tvalid_q;

	// memories
	logic [47:0] spin_mem [efs_pkg::NODE_COUNT];
	logic [31:0] isat_mem [efs_pkg::NODE_COUNT];
	logic [15:0] exch_mem [efs_pkg::NODE_COUNT];
	logic [47:0] en_mem   [efs_pkg::NODE_COUNT];
	logic [12:0] ngb_mem  [efs_pkg::NGB_DEPTH];
	logic [47:0] spin_rd;
	logic [31:0] isat_rd;
	logic [15:0] exch_rd;
	logic [47:0] en_rd;
	logic [12:0] ngb_rd;

	logic [NAW-1:0] node_raddr;
	logic [GAW-1:0] ngb_waddr, ngb_raddr;
	logic           nb_ok;
	logic           en_we;
	logic [NAW-1:0] en_waddr;
	logic [47:0]    en_wdata;

	efs_pkg::mac_op_t               mac_op;
	logic signed [efs_pkg::ACC_W-1:0] acc;
	logic signed [47:0]             energy_new;
	logic [31:0]                    k_sel;
	logic [1:0]                     s_idx;
	logic signed [efs_pkg::SUM_W-1:0] s_sel;
	logic signed [efs_pkg::MAC_AW-1:0] s_lo, s_hi;
	logic signed [16:0]             dspin;

	efs_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mac_op),
		.acc    (acc)
	);

	assign cfg_ready = 1'b1;

	// neighbour table address: node*6 + slot
	assign ngb_waddr = (GAW'(in_node) << 2) + (GAW'(in_node) << 1) + GAW'(in_slot);
	assign ngb_raddr = (GAW'(node_q) << 2) + (GAW'(node_q) << 1) + GAW'(j_q);
	assign nb_ok      = !ngb_rd[12] && (32'(ngb_rd[11:0]) < efs_pkg::NODE_COUNT);
	assign node_raddr = (state_q == efs_pkg::ST_CHK_NGB) ? ngb_rd[NAW-1:0] : node_q;

	assign energy_new = efs_pkg::sat48(acc);
	assign en_we      = (state_q == efs_pkg::ST_CLEAR) || (state_q == efs_pkg::ST_EN_SAV);
	assign en_waddr   = (state_q == efs_pkg::ST_CLEAR) ? clr_q : node_q;
	assign en_wdata   = (state_q == efs_pkg::ST_CLEAR) ? 48'd0 : energy_new;
	assign out_go     = !m_tvalid_q || m_tready;

	always_ff @(posedge clk) begin
		if (s_xfer && s_tuser == efs_pkg::REQ_WR_NODE && in_node_ok) begin
			spin_mem[in_node[NAW-1:0]] <= in_spin;
			isat_mem[in_node[NAW-1:0]] <= in_isat;
			exch_mem[in_node[NAW-1:0]] <= in_exch;
		end
		spin_rd <= spin_mem[node_raddr];
		isat_rd <= isat_mem[node_raddr];
		exch_rd <= exch_mem[node_raddr];
	end

	always_ff @(posedge clk) begin
		if (s_xfer && s_tuser == efs_pkg::REQ_WR_NGB && in_node_ok
				&& 32'(in_slot) < efs_pkg::NEIGHBOURS)
			ngb_mem[ngb_waddr] <= in_ngb;
		ngb_rd <= ngb_mem[ngb_raddr];
	end

	always_ff @(posedge clk) begin
		if (en_we)
			en_mem[en_waddr] <= en_wdata;
		en_rd <= en_mem[node_q];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			efs_pkg::ST_CLEAR:
				if (clr_q == NAW'(efs_pkg::NODE_COUNT - 1)) state_d = efs_pkg::ST_IDLE;
			efs_pkg::ST_IDLE: begin
				if (s_xfer && s_tuser == efs_pkg::REQ_COMPUTE) state_d = efs_pkg::ST_RD_OWN;
				if (s_xfer && s_tuser == efs_pkg::REQ_TOTAL)   state_d = efs_pkg::ST_TOT;
			end
			efs_pkg::ST_RD_OWN:  state_d = efs_pkg::ST_LD_OWN;
			efs_pkg::ST_LD_OWN:
				if (!node_ok_q || isat_rd == 32'd0) state_d = efs_pkg::ST_OUT;
				else state_d = efs_pkg::ST_RD_NGB;
			efs_pkg::ST_RD_NGB:  state_d = efs_pkg::ST_CHK_NGB;
			efs_pkg::ST_CHK_NGB: state_d = nb_ok ? efs_pkg::ST_LD_NB : efs_pkg::ST_NEXT;
			efs_pkg::ST_LD_NB:
				state_d = (isat_rd == 32'd0) ? efs_pkg::ST_NEXT : efs_pkg::ST_DIFF;
			efs_pkg::ST_DIFF:    state_d = efs_pkg::ST_DIFF_W;
			efs_pkg::ST_DIFF_W:  state_d = efs_pkg::ST_KL;
			efs_pkg::ST_KL:      state_d = efs_pkg::ST_KH;
			efs_pkg::ST_KH:      state_d = efs_pkg::ST_K_W;
			efs_pkg::ST_K_W:     state_d = efs_pkg::ST_ACC;
			efs_pkg::ST_ACC:
				state_d = (c_q == 2'd2) ? efs_pkg::ST_NEXT : efs_pkg::ST_DIFF;
			efs_pkg::ST_NEXT:
				state_d = (j_q == 3'd5) ? efs_pkg::ST_FLD : efs_pkg::ST_RD_NGB;
			efs_pkg::ST_FLD:     if (p_q == 3'd3) state_d = efs_pkg::ST_FLD_W;
			efs_pkg::ST_FLD_W:   state_d = efs_pkg::ST_FLD_SAV;
			efs_pkg::ST_FLD_SAV:
				state_d = (c_q == 2'd2) ? efs_pkg::ST_EN : efs_pkg::ST_FLD;
			efs_pkg::ST_EN:      if (p_q == 3'd5) state_d = efs_pkg::ST_EN_W;
			efs_pkg::ST_EN_W:    state_d = efs_pkg::ST_EN_SAV;
			efs_pkg::ST_EN_SAV:  state_d = efs_pkg::ST_OUT;
			efs_pkg::ST_TOT:     if (p_q == 3'd3) state_d = efs_pkg::ST_TOT_W;
			efs_pkg::ST_TOT_W:   state_d = efs_pkg::ST_TOT_SAV;
			efs_pkg::ST_TOT_SAV: state_d = efs_pkg::ST_OUT;
			efs_pkg::ST_OUT:     if (out_go) state_d = efs_pkg::ST_IDLE;
			default:             state_d = efs_pkg::ST_IDLE;
		endcase
	end

	// MAC operand selection
	assign s_idx = (state_q == efs_pkg::ST_EN) ? p_q[2:1] : c_q;
	assign s_sel = s_q[s_idx];
	assign s_lo  = efs_pkg::MAC_AW'({1'b0, s_sel[26:0]});
	assign s_hi  = efs_pkg::MAC_AW'($signed(s_sel[53:27]));
	assign dspin = 17'(nb_spin_q[c_q]) - 17'(own_spin_q[c_q]);
	assign k_sel = cfg_q[j_q[2:1]];

	// outputs of the sequencer
	always_comb begin
		s_tready = (state_q == efs_pkg::ST_IDLE);
		mac_op   = '0;
		case (state_q)
			efs_pkg::ST_DIFF: begin
				// v = 2A * (spin[nb] - spin[node])
				mac_op.vld = 1'b1;
				mac_op.clr = 1'b1;
				mac_op.a   = efs_pkg::MAC_AW'(dspin);
				mac_op.b   = efs_pkg::MAC_BW'({own_exch_q, 1'b0});
			end
			efs_pkg::ST_KL: begin
				mac_op.vld = 1'b1;
				mac_op.clr = 1'b1;
				mac_op.a   = acc[efs_pkg::MAC_AW-1:0];
				mac_op.b   = efs_pkg::MAC_BW'(k_sel[15:0]);
			end
			efs_pkg::ST_KH: begin
				mac_op.vld   = 1'b1;
				mac_op.shift = 6'd16;
				mac_op.a     = acc[efs_pkg::MAC_AW-1:0];
				mac_op.b     = efs_pkg::MAC_BW'(k_sel[31:16]);
			end
			efs_pkg::ST_FLD: begin
				mac_op.vld = 1'b1;
				mac_op.clr = (p_q == 3'd0);
				mac_op.a   = p_q[1] ? s_hi : s_lo;
				mac_op.b   = efs_pkg::MAC_BW'(p_q[0] ? own_isat_q[31:16] : own_isat_q[15:0]);
				case (p_q[1:0])
					2'd0:    mac_op.shift = 6'd0;
					2'd1:    mac_op.shift = 6'd16;
					2'd2:    mac_op.shift = 6'd27;
					default: mac_op.shift = 6'd43;
				endcase
			end
			efs_pkg::ST_EN: begin
				// accumulate -(S . spin)
				mac_op.vld   = 1'b1;
				mac_op.clr   = (p_q == 3'd0);
				mac_op.a     = p_q[0] ? s_hi : s_lo;
				mac_op.b     = -efs_pkg::MAC_BW'(own_spin_q[p_q[2:1]]);
				mac_op.shift = p_q[0] ? 6'd27 : 6'd0;
			end
			efs_pkg::ST_TOT: begin
				// signed upper word, unsigned lower word
				mac_op.vld = 1'b1;
				mac_op.clr = (p_q == 3'd0);
				mac_op.a   = p_q[1] ? efs_pkg::MAC_AW'($signed(sum_q[63:32]))
				                    : efs_pkg::MAC_AW'({1'b0, sum_q[31:0]});
				mac_op.b   = efs_pkg::MAC_BW'(p_q[0] ? cfg_q[efs_pkg::CFG_VOLUME][31:16]
				                                     : cfg_q[efs_pkg::CFG_VOLUME][15:0]);
				case (p_q[1:0])
					2'd0:    mac_op.shift = 6'd0;
					2'd1:    mac_op.shift = 6'd16;
					2'd2:    mac_op.shift = 6'd32;
					default: mac_op.shift = 6'd48;
				endcase
			end
			default: mac_op = '0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= efs_pkg::ST_CLEAR;
			clr_q      <= '0;
			c_q        <= '0;
			j_q        <= '0;
			p_q        <= '0;
			m_tvalid_q <= 1'b0;
			sum_q      <= '0;
			cfg_q[efs_pkg::CFG_INV_DX] <= efs_pkg::CFG_RESET;
			cfg_q[efs_pkg::CFG_INV_DY] <= efs_pkg::CFG_RESET;
			cfg_q[efs_pkg::CFG_INV_DZ] <= efs_pkg::CFG_RESET;
			cfg_q[efs_pkg::CFG_VOLUME] <= efs_pkg::CFG_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready)
				cfg_q[cfg_index] <= cfg_data;
			if (state_q == efs_pkg::ST_CLEAR)
				clr_q <= clr_q + NAW'(1);
			case (state_q)
				efs_pkg::ST_IDLE, efs_pkg::ST_LD_OWN: begin
					c_q <= '0;
					j_q <= '0;
					p_q <= '0;
				end
				efs_pkg::ST_ACC, efs_pkg::ST_FLD_SAV:
					c_q <= (c_q == 2'd2) ? 2'd0 : c_q + 2'd1;
				efs_pkg::ST_NEXT: begin
					j_q <= j_q + 3'd1;
					c_q <= '0;
					p_q <= '0;
				end
				efs_pkg::ST_FLD, efs_pkg::ST_TOT:
					p_q <= (p_q == 3'd3) ? 3'd0 : p_q + 3'd1;
				efs_pkg::ST_EN:
					p_q <= (p_q == 3'd5) ? 3'd0 : p_q + 3'd1;
				efs_pkg::ST_EN_SAV:
					sum_q <= sum_q + 64'(energy_new) - 64'(own_en_q);
				default: ;
			endcase
			if (state_q == efs_pkg::ST_OUT && out_go)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			efs_pkg::ST_IDLE:
				if (s_xfer) begin
					node_q    <= in_node[NAW-1:0];
					node_ok_q <= in_node_ok;
					kind_q    <= (s_tuser == efs_pkg::REQ_TOTAL);
					fld_q[0]  <= '0;
					fld_q[1]  <= '0;
					fld_q[2]  <= '0;
					en_q      <= '0;
					tot_q     <= '0;
				end
			efs_pkg::ST_LD_OWN: begin
				own_spin_q[0] <= spin_rd[15:0];
				own_spin_q[1] <= spin_rd[31:16];
				own_spin_q[2] <= spin_rd[47:32];
				own_isat_q    <= isat_rd;
				own_exch_q    <= exch_rd;
				own_en_q      <= en_rd;
				s_q[0]        <= '0;
				s_q[1]        <= '0;
				s_q[2]        <= '0;
				// non-magnetic node reports its stored energy
				if (node_ok_q && isat_rd == 32'd0)
					en_q <= en_rd;
			end
			efs_pkg::ST_LD_NB: begin
				nb_spin_q[0] <= spin_rd[15:0];
				nb_spin_q[1] <= spin_rd[31:16];
				nb_spin_q[2] <= spin_rd[47:32];
			end
			efs_pkg::ST_ACC:
				s_q[c_q] <= s_q[c_q] + efs_pkg::SUM_W'(acc >>> 16);
			efs_pkg::ST_FLD_SAV:
				fld_q[c_q] <= efs_pkg::sat48(acc);
			efs_pkg::ST_EN_SAV:
				en_q <= energy_new;
			efs_pkg::ST_TOT_SAV:
				tot_q <= efs_pkg::sat64(acc);
			efs_pkg::ST_OUT:
				if (out_go) begin
					m_tdata_q <= {tot_q, en_q, fld_q[2], fld_q[1], fld_q[0]};
					m_tuser_q <= kind_q;
				end
			default: ;
		endcase
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

	// checks
	`ASSERT_CLK(a_out_from_seq, clk, arst_n, $rose(m_tvalid) |-> $past(state_q == efs_pkg::ST_OUT), "result offered outside output state")
	`ASSERT_CLK(a_total_clean, clk, arst_n, (m_tvalid && m_tuser[0]) |-> (m_tdata[191:0] == 192'd0), "total result carries node fields")
	`ASSERT_CLK(a_node_clean, clk, arst_n, (m_tvalid && !m_tuser[0]) |-> (m_tdata[255:192] == 64'd0), "node result carries total")
	`ASSERT_NEVER(a_busy_in, clk, arst_n, s_tready && state_q == efs_pkg::ST_CLEAR, "input taken during clear sweep")

endmodule

FILE: tb/efs_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// efs_checker
// Watches the request, result and config channels of the exchange stencil.
// It keeps its own copy of the node stores and registers, predicts every
// result and compares each result transfer field by field with the oldest
// prediction.
// ---------------------------------------------------------------------------
module efs_checker
	import efs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [127:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [255:0] m_tdata,
	input  logic [0:0]   m_tuser,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	output int           failures,
	output int           pending
);

	typedef struct {
		logic               kind;
		logic signed [47:0] fx, fy, fz, energy;
		logic signed [63:0] total;
	} stencil_result_t;

	stencil_result_t     expected_results[$];

	logic signed [15:0]  spin_mem[NODE_COUNT][3];
	logic [31:0]         sat_mem[NODE_COUNT];
	logic [15:0]         coeff_mem[NODE_COUNT];
	logic signed [12:0]  link_mem[NGB_DEPTH];
	logic signed [47:0]  energy_mem[NODE_COUNT];
	logic signed [63:0]  energy_total;
	logic [31:0]         spacing_regs[CFG_REGS];

	assign pending = expected_results.size();

	// floor(x / 2^16), clamped to a signed range of w bits
	function automatic logic signed [127:0] scale_down(input logic signed [127:0] x,
			input int w);
		logic signed [127:0] t, hi;
		t = x >>> 16;
		hi = (128'sd1 <<< (w - 1)) - 128'sd1;
		if (t > hi)
			return hi;
		if (t < -hi - 128'sd1)
			return -hi - 128'sd1;
		return t;
	endfunction

	function automatic stencil_result_t exchange_field(input int n);
		stencil_result_t     r;
		logic signed [127:0] s[3], dot, twoa, k, d, ms;
		int                  nb;
		r = '{default: '0};
		if (sat_mem[n] == 0) begin
			// no material: nothing moves, stored energy comes back
			r.energy = energy_mem[n];
			return r;
		end
		s = '{default: '0};
		dot = 0;
		twoa = 128'(coeff_mem[n]) * 2;
		for (int j = 0; j < NEIGHBOURS; j++) begin
			nb = int'(link_mem[n * NEIGHBOURS + j]);
			if (nb < 0 || nb >= NODE_COUNT || sat_mem[nb] == 0)
				continue;
			k = 128'(spacing_regs[j / 2]);
			for (int c = 0; c < 3; c++) begin
				d = 128'(spin_mem[nb][c]);
				d = d - 128'(spin_mem[n][c]);
				s[c] = s[c] + ((twoa * d * k) >>> 16);
			end
		end
		ms = 128'(sat_mem[n]);
		for (int c = 0; c < 3; c++)
			dot = dot + s[c] * 128'(spin_mem[n][c]);
		r.fx = 48'(scale_down(s[0] * ms, 48));
		r.fy = 48'(scale_down(s[1] * ms, 48));
		r.fz = 48'(scale_down(s[2] * ms, 48));
		r.energy = 48'(scale_down(-dot, 48));
		energy_total = energy_total + 64'(r.energy) - 64'(energy_mem[n]);
		energy_mem[n] = r.energy;
		return r;
	endfunction

	task automatic check_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		stencil_result_t r;
		int              n;
		if (!arst_n) begin
			for (int i = 0; i < NODE_COUNT; i++)
				energy_mem[i] = '0;
			energy_total = '0;
			for (int i = 0; i < CFG_REGS; i++)
				spacing_regs[i] = CFG_RESET;
			expected_results.delete();
			failures = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				spacing_regs[cfg_index] = cfg_data;

			if (s_tvalid && s_tready) begin
				n = int'(s_tdata[11:0]);
				case (s_tuser)
				REQ_WR_NODE: begin
					spin_mem[n][0] = s_tdata[27:12];
					spin_mem[n][1] = s_tdata[43:28];
					spin_mem[n][2] = s_tdata[59:44];
					sat_mem[n] = s_tdata[91:60];
					coeff_mem[n] = s_tdata[107:92];
				end
				REQ_WR_NGB: begin
					// slots 6 and 7 do not exist and are dropped
					if (s_tdata[110:108] < NEIGHBOURS)
						link_mem[n * NEIGHBOURS + int'(s_tdata[110:108])] = s_tdata[123:111];
				end
				REQ_COMPUTE:
					expected_results.push_back(exchange_field(n));
				default: begin
					r = '{default: '0};
					r.kind = 1'b1;
					r.total = 64'(scale_down(128'(energy_total) *
						128'(spacing_regs[CFG_VOLUME]), 64));
					expected_results.push_back(r);
				end
				endcase
			end

			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with no request outstanding");
					failures++;
				end else begin
					r = expected_results.pop_front();
					check_field("result_kind", 64'(r.kind), 64'(m_tuser));
					check_field("field_x", 64'(r.fx), 64'($signed(m_tdata[47:0])));
					check_field("field_y", 64'(r.fy), 64'($signed(m_tdata[95:48])));
					check_field("field_z", 64'(r.fz), 64'($signed(m_tdata[143:96])));
					check_field("node_energy", 64'(r.energy),
						64'($signed(m_tdata[191:144])));
					check_field("total_energy", r.total, m_tdata[255:192]);
				end
			end
		end
	end

endmodule

FILE: tb/tb_exchange_field_stencil.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_exchange_field_stencil
// Stimulus and verdict for the exchange stencil. A short directed run hits
// spin and coefficient extremes, missing and non-magnetic neighbours and
// dropped slots; then phases of random traffic under different spacing and
// volume settings, with the sender and receiver idling in turns and one long
// receiver hold-off. All checking lives in efs_checker.
// ---------------------------------------------------------------------------
module tb_exchange_field_stencil;
	import efs_pkg::*;

	// request payload, msb first; packs straight onto s_tdata
	typedef struct packed {
		logic [3:0]         pad;
		logic signed [12:0] ngb;
		logic [2:0]         slot;
		logic [15:0]        coeff;
		logic [31:0]        sat;
		logic signed [15:0] sz, sy, sx;
		logic [11:0]        node;
	} stencil_req_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [255:0] m_tdata;
	logic [0:0]   m_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [31:0]  cfg_data;
	int           failures;
	int           pending;

	// idle / stall percentages, switched by the stimulus
	int           gap_pct;
	int           stall_pct;
	bit           hold_req;

	// what the stimulus knows has been written: only such entries get read
	bit           node_written[NODE_COUNT];
	bit [5:0]     slots_set[NODE_COUNT];
	bit           is_ready[NODE_COUNT];
	int           written_nodes[$];
	int           ready_nodes[$];

	exchange_field_stencil dut (.*);

	efs_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 3000;
			end
			if (hold_left > 0) begin
				m_tready = 1'b0;
				hold_left--;
			end else
				m_tready = ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic void note_write(input stencil_req_t r, input logic [1:0] kind);
		int n;
		n = int'(r.node);
		if (kind == REQ_WR_NODE && !node_written[n]) begin
			node_written[n] = 1'b1;
			written_nodes.push_back(n);
		end
		if (kind == REQ_WR_NGB && r.slot < NEIGHBOURS)
			slots_set[n][r.slot] = 1'b1;
		if (!is_ready[n] && node_written[n] && &slots_set[n]) begin
			is_ready[n] = 1'b1;
			ready_nodes.push_back(n);
		end
	endfunction

	// one request transfer; valid stays high into the next call unless a gap
	task automatic send(input stencil_req_t r, input logic [1:0] kind);
		@(negedge clk);
		if ($urandom_range(99) < gap_pct) begin
			s_tvalid = 1'b0;
			repeat (1 + $urandom_range(3)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = r;
		s_tuser = kind;
		note_write(r, kind);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		s_tvalid = 1'b0;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// all results back, then room for the longest compute before touching regs
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		wait (pending == 0);
		repeat (200) @(posedge clk);
	endtask

	function automatic stencil_req_t noise_req();
		stencil_req_t r;
		r = {$urandom, $urandom, $urandom, $urandom};
		r.pad = '0;
		return r;
	endfunction

	function automatic stencil_req_t node_req(input int n, input int x, input int y,
			input int z, input logic [31:0] sat, input logic [15:0] coeff);
		stencil_req_t r;
		r = '0;
		r.node = 12'(n);
		r.sx = 16'(x);
		r.sy = 16'(y);
		r.sz = 16'(z);
		r.sat = sat;
		r.coeff = coeff;
		return r;
	endfunction

	function automatic stencil_req_t link_req(input int n, input int slot, input int nb);
		stencil_req_t r;
		r = '0;
		r.node = 12'(n);
		r.slot = 3'(slot);
		r.ngb = 13'(nb);
		return r;
	endfunction

	task automatic directed_part();
		int links0[6];
		links0 = '{4095, 1, -1, 2, -4096, 4095};
		send(node_req(0, 32767, -32768, 0, 32'hFFFF_FFFF, 16'hFFFF), REQ_WR_NODE);
		send(node_req(4095, -32768, 32767, -32768, 32'd1, 16'hFFFF), REQ_WR_NODE);
		send(node_req(1, 1000, -1000, 5, 32'd0, 16'd7), REQ_WR_NODE);
		send(node_req(2, -32768, -32768, -32768, 32'h0001_0000, 16'd0), REQ_WR_NODE);
		for (int j = 0; j < NEIGHBOURS; j++) begin
			send(link_req(0, j, links0[j]), REQ_WR_NGB);
			send(link_req(4095, j, 0), REQ_WR_NGB);
		end
		// nonexistent slots must not disturb anything
		send(link_req(0, 6, 1), REQ_WR_NGB);
		send(link_req(0, 7, 2), REQ_WR_NGB);
		for (int j = 0; j < NEIGHBOURS; j++) begin
			send(link_req(1, j, -1), REQ_WR_NGB);
			send(link_req(2, j, 0), REQ_WR_NGB);
		end
		send(node_req(0, 0, 0, 0, 0, 0), REQ_COMPUTE);
		send(node_req(4095, 0, 0, 0, 0, 0), REQ_COMPUTE);
		send(node_req(1, 0, 0, 0, 0, 0), REQ_COMPUTE);
		send(node_req(2, 0, 0, 0, 0, 0), REQ_COMPUTE);
		send(noise_req(), REQ_TOTAL);
	endtask

	task automatic random_item();
		stencil_req_t r;
		int           pick;
		int           kind;
		r = noise_req();
		pick = $urandom_range(99);
		if (pick < 25 || (pick < 80 && pick >= 45 && ready_nodes.size() == 0)) begin
			// node write: mostly rewrites, some fresh nodes
			if ($urandom_range(99) >= 15)
				r.node = 12'(written_nodes[$urandom_range(written_nodes.size() - 1)]);
			case ($urandom_range(9))
			0: r.sat = '0;
			1: r.sat = 32'hFFFF_FFFF;
			2: r.sat = 32'(1 + $urandom_range(65535));
			default: ;
			endcase
			if ($urandom_range(9) == 0)
				r.sx = 16'sh8000;
			kind = REQ_WR_NODE;
		end else if (pick < 45) begin
			// links point at written nodes or are absent
			if ($urandom_range(99) >= 15)
				r.node = 12'(written_nodes[$urandom_range(written_nodes.size() - 1)]);
			if ($urandom_range(99) < 75)
				r.ngb = 13'(written_nodes[$urandom_range(written_nodes.size() - 1)]);
			else
				r.ngb = {1'b1, 12'($urandom)};
			r.slot = ($urandom_range(19) == 0) ? 3'(6 + $urandom_range(1))
				: 3'($urandom_range(5));
			kind = REQ_WR_NGB;
		end else if (pick < 88) begin
			r.node = 12'(ready_nodes[$urandom_range(ready_nodes.size() - 1)]);
			kind = REQ_COMPUTE;
		end else
			kind = REQ_TOTAL;
		send(r, 2'(kind));
	endtask

	initial begin
		logic [31:0] setting;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		gap_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed_part();

		for (int phase = 0; phase < 5; phase++) begin
			if (phase > 0) begin
				drain();
				for (int i = 0; i < CFG_REGS; i++) begin
					case (phase)
					1: setting = 32'hFFFF_FFFF;
					2: setting = 32'h0;
					3: setting = $urandom;
					default: setting = $urandom_range(32'h2_0000);
					endcase
					write_reg(2'(i), setting);
				end
			end
			for (int i = 0; i < 380; i++) begin
				// idling regime changes every 95 transfers
				case ((i / 95) % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 65; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 65; end
				default: begin gap_pct = 27; stall_pct = 27; end
				endcase
				// long receiver hold-off while requests keep coming
				if (phase == 1 && i == 10)
					hold_req = 1'b1;
				random_item();
			end
		end

		drain();
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
